/* design/shs_pkg.sv */
package shs_pkg;

    // block store: sixteen big-endian 32-bit words
    localparam int BLK_WORDS   = 16;
    localparam int BLK_AW      = $clog2(BLK_WORDS);
    // chaining words
    localparam int CHAIN_WORDS = 8;
    localparam int CHAIN_AW    = $clog2(CHAIN_WORDS);
    localparam int ROUNDS      = 64;

    // input operation codes
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT_RD,
        ST_OUT_SHOW
    } t_state;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [CHAIN_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // round function sums
    function automatic logic [31:0] big_sum0(input logic [31:0] x);
        big_sum0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sum1(input logic [31:0] x);
        big_sum1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // message schedule sums
    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

/* design/sha256_stream_hash.sv */
// Streaming SHA-256 hasher. Absorb items (one message byte each) are taken one per cycle;
// every 64th byte starts a block compression (a read of the eight chaining words, a
// schedule lead-in step and 64 rounds, a read-add-write of each chaining word) during which
// no item is taken, since one round unit and a chaining memory with one read port and one
// write port do the work. A finish item writes the padding one word a cycle (up to 16 words
// per padding block), compresses one or two padding blocks, then delivers the eight digest
// words, each read and then held until taken, word 0 first, with last_word on word 7; the
// block is then ready for a new message with the initial hash values restored.
module sha256_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import shs_pkg::*;

    // control registers
    t_state      r_state, n_state;
    logic [6:0]  r_cnt, n_cnt;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic        r_fin, n_fin;
    logic        r_last_blk, n_last_blk;
    logic        r_first, n_first;
    logic [CHAIN_WORDS-1:0] r_cv_valid;

    // datapath registers
    logic [31:0] r_stage;
    logic [31:0] r_w [BLK_WORDS];
    logic [31:0] r_wk;
    logic [31:0] r_v [CHAIN_WORDS];
    logic [31:0] r_bq;
    logic [31:0] r_cq;

    // memories
    logic [31:0] blk_mem [BLK_WORDS];
    logic [31:0] chain_mem [CHAIN_WORDS];

    // strobes
    logic                blk_we, blk_re;
    logic [BLK_AW-1:0]   blk_wa, blk_ra;
    logic [31:0]         blk_wd;
    logic                cv_we, cv_re, cv_clear;
    logic [CHAIN_AW-1:0] cv_wa, cv_ra;
    logic                sched_en, round_en, load_shift, upd_shift, stage_en;

    logic        in_acc;
    logic [63:0] pad_ext;
    logic [31:0] pad_word;
    logic [31:0] w_new;
    logic [31:0] t1, t2;
    logic [31:0] cv_wd;

    assign in_acc  = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT_SHOW);
    assign o_digest_word = r_cq;
    assign o_word_index  = r_cnt[2:0];
    assign o_last_word   = (r_cnt[2:0] == 3'(CHAIN_WORDS - 1));

    // first padding word: pending bytes, then the pad byte, then zeros
    assign pad_ext  = {24'b0, r_stage, PAD_BYTE} << {~r_fill[1:0], 3'b000};
    assign pad_word = pad_ext[31:0];

    // schedule word for step r_cnt
    assign w_new = (r_cnt[6:4] == 3'b000) ? r_bq :
                   small_sig1(r_w[14]) + r_w[9] + small_sig0(r_w[1]) + r_w[0];

    // round sums
    assign t1 = r_v[7] + big_sum1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + r_wk;
    assign t2 = big_sum0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign cv_wd = r_cq + r_v[0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_fill     <= '0;
            r_bits     <= '0;
            r_fin      <= 1'b0;
            r_last_blk <= 1'b0;
            r_first    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_fill     <= n_fill;
            r_bits     <= n_bits;
            r_fin      <= n_fin;
            r_last_blk <= n_last_blk;
            r_first    <= n_first;
        end
    end

    // next state and strobes
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_fill     = r_fill;
        n_bits     = r_bits;
        n_fin      = r_fin;
        n_last_blk = r_last_blk;
        n_first    = r_first;
        blk_we     = 1'b0;
        blk_wa     = r_fill[5:2];
        blk_wd     = {r_stage[23:0], i_data_byte};
        blk_re     = 1'b0;
        blk_ra     = '0;
        cv_we      = 1'b0;
        cv_wa      = CHAIN_AW'(r_cnt[2:0] - 3'd1);
        cv_re      = 1'b0;
        cv_ra      = r_cnt[2:0];
        cv_clear   = 1'b0;
        sched_en   = 1'b0;
        round_en   = 1'b0;
        load_shift = 1'b0;
        upd_shift  = 1'b0;
        stage_en   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_op == OP_FINISH) begin
                        n_fin      = 1'b1;
                        n_first    = 1'b1;
                        n_last_blk = (r_fill[5:3] != 3'b111);
                        n_cnt      = {3'b000, r_fill[5:2]};
                        n_state    = ST_PAD;
                    end else begin
                        stage_en = 1'b1;
                        blk_we   = (r_fill[1:0] == 2'b11);
                        n_fill   = r_fill + 6'd1;
                        n_bits   = r_bits + 64'd8;
                        if (r_fill == 6'd63) begin
                            n_cnt   = '0;
                            n_state = ST_LOAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                // one padding word a cycle, length in the last two words of the final block
                blk_we  = 1'b1;
                blk_wa  = r_cnt[3:0];
                n_first = 1'b0;
                if (r_first) begin
                    blk_wd = pad_word;
                end else if (r_last_blk && r_cnt[3:0] == 4'd14) begin
                    blk_wd = r_bits[63:32];
                end else if (r_last_blk && r_cnt[3:0] == 4'd15) begin
                    blk_wd = r_bits[31:0];
                end else begin
                    blk_wd = '0;
                end
                if (r_cnt[3:0] == 4'd15) begin
                    n_cnt   = '0;
                    n_state = ST_LOAD;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            ST_LOAD: begin
                // chaining words into the working registers
                cv_re      = (r_cnt[3] == 1'b0);
                load_shift = (r_cnt != 7'd0);
                n_cnt      = r_cnt + 7'd1;
                if (r_cnt == 7'(CHAIN_WORDS)) begin
                    blk_re  = 1'b1;
                    blk_ra  = '0;
                    n_cnt   = '0;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                // schedule one step ahead of the round
                sched_en = (r_cnt[6] == 1'b0);
                round_en = (r_cnt != 7'd0);
                blk_re   = (r_cnt < 7'(BLK_WORDS - 1));
                blk_ra   = r_cnt[3:0] + 4'd1;
                n_cnt    = r_cnt + 7'd1;
                if (r_cnt == 7'(ROUNDS)) begin
                    n_cnt   = '0;
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // read, add, write back each chaining word
                cv_re     = (r_cnt[3] == 1'b0);
                cv_we     = (r_cnt != 7'd0);
                upd_shift = (r_cnt != 7'd0);
                n_cnt     = r_cnt + 7'd1;
                if (r_cnt == 7'(CHAIN_WORDS)) begin
                    n_cnt = '0;
                    if (!r_fin) begin
                        n_state = ST_IDLE;
                    end else if (r_last_blk) begin
                        n_state = ST_OUT_RD;
                    end else begin
                        n_last_blk = 1'b1;
                        n_first    = 1'b0;
                        n_state    = ST_PAD;
                    end
                end
            end
            ST_OUT_RD: begin
                cv_re   = 1'b1;
                n_state = ST_OUT_SHOW;
            end
            ST_OUT_SHOW: begin
                if (i_ready) begin
                    if (o_last_word) begin
                        cv_clear = 1'b1;
                        n_fill   = '0;
                        n_bits   = '0;
                        n_fin    = 1'b0;
                        n_cnt    = '0;
                        n_state  = ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 7'd1;
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // block store
    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            blk_mem[blk_wa] <= blk_wd;
        end
        if (blk_re) begin
            r_bq <= blk_mem[blk_ra];
        end
    end

    // chaining memory, unwritten words read as the initial hash
    always_ff @(posedge i_clk) begin
        if (cv_we) begin
            chain_mem[cv_wa] <= cv_wd;
        end
        if (cv_re) begin
            r_cq <= r_cv_valid[cv_ra] ? chain_mem[cv_ra] : INIT_HASH[cv_ra];
        end
    end

    // chaining word valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cv_clear) begin
            r_cv_valid <= '0;
        end else if (cv_we) begin
            r_cv_valid[cv_wa] <= 1'b1;
        end
    end

    // byte gathering
    always_ff @(posedge i_clk) begin
        if (stage_en) begin
            r_stage <= {r_stage[23:0], i_data_byte};
        end
    end

    // message schedule window
    always_ff @(posedge i_clk) begin
        if (sched_en) begin
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BLK_WORDS-1] <= w_new;
            r_wk <= w_new + ROUND_K[r_cnt[5:0]];
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (load_shift) begin
            for (int i = 0; i < CHAIN_WORDS - 1; i++) begin
                r_v[i] <= r_v[i+1];
            end
            r_v[CHAIN_WORDS-1] <= r_cq;
        end else if (upd_shift) begin
            for (int i = 0; i < CHAIN_WORDS - 1; i++) begin
                r_v[i] <= r_v[i+1];
            end
            r_v[CHAIN_WORDS-1] <= r_v[0];
        end else if (round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // no block store write while the block is being compressed
    a_no_blk_write_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND || r_state == ST_LOAD) |-> !blk_we)
        else $error("block store written during compression");

    // chaining memory written only by the update pass
    a_chain_write_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cv_we |-> (r_state == ST_UPDATE && r_fin == $past(r_fin)))
        else $error("chaining word written outside update");

    // after the final digest word the initial hash is back
    a_chain_reset_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_word) |=> (r_cv_valid == '0 && r_fill == '0))
        else $error("chain not restored after digest");

    // digest words only follow a finish that reached its final block
    a_out_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_fin && r_last_blk && !o_ready))
        else $error("digest word outside a finish");

endmodule
